[sv/nlms_adaptive_filter_top_defines.svh]
// Assertion macros shared by the NLMS filter RTL.
// Needs a clock i_clk and an active-low reset i_rst_n in scope at the point of use.
`ifndef NLMS_ADAPTIVE_FILTER_TOP_DEFINES_SVH
`define NLMS_ADAPTIVE_FILTER_TOP_DEFINES_SVH

// same-cycle implication
`define NAF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/naf_pkg.sv]
// Shared types and fixed widths for the NLMS adaptive filter.
// No dependencies.
package naf_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 32;
    localparam int STEP_W    = 16;
    localparam int SE_W      = 32;   // step * error
    localparam int PROD_W    = 48;   // coef * tap, se * tap
    localparam int DIV_SHIFT = 14;
    localparam int QUOT_W    = 46;   // |delta| < 2^46 since energy >= tap^2
    localparam int NUM_W     = QUOT_W + DIV_SHIFT;
    localparam int FRAC_W    = 30;
    localparam int STEP_RST  = 1311;

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b00_0000_0001,
        ST_IDLE  = 10'b00_0000_0010,
        ST_ACC   = 10'b00_0000_0100,
        ST_EST   = 10'b00_0000_1000,
        ST_ERR   = 10'b00_0001_0000,
        ST_SE    = 10'b00_0010_0000,
        ST_RD    = 10'b00_0100_0000,
        ST_MUL   = 10'b00_1000_0000,
        ST_DIV   = 10'b01_0000_0000,
        ST_WR    = 10'b10_0000_0000
    } t_state;

endpackage

[sv/naf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module naf_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                              i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [W-1:0]                              o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[sv/naf_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned.
// Uses naf_pkg. Caller guarantees the quotient fits QUOT_W bits.
module naf_div #(
    parameter int DEN_W = 40
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [naf_pkg::NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]           i_den,
    output logic                       o_done,
    output logic [naf_pkg::QUOT_W-1:0] o_quot
);
    localparam int QW   = naf_pkg::QUOT_W;
    localparam int CNTW = $clog2(QW);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QW-1:0]   r_q;

    logic [DEN_W:0]  trial;
    logic [DEN_W:0]  diff;
    logic            ge;

    assign trial = {r_rem, r_q[QW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_W'(i_num[naf_pkg::NUM_W-1:QW]);
            r_q   <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_q   <= {r_q[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

[sv/nlms_adaptive_filter_top.sv]
// Top level of the NLMS adaptive FIR filter.
// Uses naf_pkg, naf_ram, naf_div and nlms_adaptive_filter_top_defines.svh.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata[15:0] reference, [31:16] desired
//  m_axis    out  tvalid/tready           tdata[15:0] error, [31:16] estimate
//  cfg       in   i_cfg_wr_en             i_cfg_wr_data = step size, Q0.16
//
// One item at a time: accept, reads of every tap (one per RAM per cycle) and
// pipeline drain, round, saturate, step setup, then an update of each tap
// (read, multiply, the one-bit-per-cycle divider, write back).
// After reset a clearing pass zeroes both RAMs; no input is taken during it.
// A result waiting on m_axis holds the next item at its error stage; the
// next input is still taken while a result waits.
`include "nlms_adaptive_filter_top_defines.svh"

module nlms_adaptive_filter_top #(
    parameter int TAPS = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] reference_sample, [31:16] desired_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] error_sample, [31:16] estimate_sample
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);
    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW    = $clog2(TAPS + 1);
    localparam int ACC_W = naf_pkg::PROD_W + CW;
    localparam int EN_W  = 31 + CW;
    localparam int SW    = naf_pkg::SAMPLE_W;
    localparam int QW    = naf_pkg::QUOT_W;

    naf_pkg::t_state r_state;

    logic [CW-1:0]  r_k;          // tap index / clear index
    logic [AW-1:0]  r_head;       // RAM address of tap 0
    logic [AW-1:0]  r_taddr;      // walking tap address
    logic [naf_pkg::STEP_W-1:0] r_step;
    logic signed [SW-1:0] r_desired;

    // estimate pass pipeline
    logic r_rd_v, r_p_v;
    logic signed [naf_pkg::PROD_W-1:0] r_p_cx;
    logic [30:0]                       r_p_tt;
    logic signed [ACC_W-1:0]           r_acc;
    logic [EN_W-1:0]                   r_energy;
    logic signed [ACC_W-1:0]           r_est_full;

    // update pass
    logic signed [SW-1:0]              r_err;
    logic signed [naf_pkg::SE_W-1:0]   r_se;
    logic [EN_W-1:0]                   r_den;
    logic signed [naf_pkg::COEF_W-1:0] r_coef;
    logic signed [naf_pkg::PROD_W-1:0] r_num;
    logic                              r_div_start;

    // output register
    logic          r_out_v;
    logic [SW-1:0] r_out_err, r_out_est;

    // RAM ports
    logic          tap_we, tap_re, coef_we, coef_re;
    logic [AW-1:0] tap_waddr, coef_waddr;
    logic [SW-1:0] tap_wdata, tap_rdata;
    logic [naf_pkg::COEF_W-1:0] coef_wdata, coef_rdata;

    logic [AW-1:0] head_inc, taddr_dec;
    logic          in_xfer, issue, out_free;
    logic signed [ACC_W:0] diff;
    logic signed [SW-1:0]  err_sat, est_sat;
    logic [naf_pkg::PROD_W-1:0] num_mag;
    logic [naf_pkg::NUM_W-1:0]  div_num;
    logic                       div_done;
    logic [QW-1:0]              div_quot;
    logic signed [QW:0]         delta;
    logic signed [QW+1:0]       coef_sum;
    logic signed [naf_pkg::COEF_W-1:0] coef_sat;

    assign head_inc  = (r_head == AW'(TAPS - 1)) ? '0 : r_head + 1'b1;
    assign taddr_dec = (r_taddr == '0) ? AW'(TAPS - 1) : r_taddr - 1'b1;
    assign s_axis_tready = (r_state == naf_pkg::ST_IDLE);
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign issue     = (r_state == naf_pkg::ST_ACC) && (r_k < CW'(TAPS));
    assign out_free  = !r_out_v || m_axis_tready;

    // error and estimate, saturated
    assign diff = (ACC_W + 1)'(r_desired) - (ACC_W + 1)'(r_est_full);
    always_comb begin
        if (diff > (ACC_W + 1)'(32767)) begin
            err_sat = 16'sh7FFF;
        end else if (diff < (ACC_W + 1)'(-32768)) begin
            err_sat = 16'sh8000;
        end else begin
            err_sat = diff[SW-1:0];
        end
        if (r_est_full > ACC_W'(32767)) begin
            est_sat = 16'sh7FFF;
        end else if (r_est_full < ACC_W'(-32768)) begin
            est_sat = 16'sh8000;
        end else begin
            est_sat = r_est_full[SW-1:0];
        end
    end

    // divider operands: |se * tap| << 14
    assign num_mag = r_num[naf_pkg::PROD_W-1] ? naf_pkg::PROD_W'(-r_num) : r_num;
    assign div_num = {num_mag[QW-1:0], {naf_pkg::DIV_SHIFT{1'b0}}};

    // coefficient update, truncating division so sign applies to magnitude
    assign delta    = r_num[naf_pkg::PROD_W-1] ? -$signed({1'b0, div_quot})
                                               : $signed({1'b0, div_quot});
    assign coef_sum = (QW + 2)'(r_coef) + (QW + 2)'(delta);
    always_comb begin
        if (coef_sum > (QW + 2)'(64'sd2147483647)) begin
            coef_sat = 32'sh7FFF_FFFF;
        end else if (coef_sum < (QW + 2)'(-64'sd2147483648)) begin
            coef_sat = 32'sh8000_0000;
        end else begin
            coef_sat = coef_sum[naf_pkg::COEF_W-1:0];
        end
    end

    // RAM port control
    always_comb begin
        tap_we     = 1'b0;
        tap_waddr  = head_inc;
        tap_wdata  = s_axis_tdata[SW-1:0];
        coef_we    = 1'b0;
        coef_waddr = r_k[AW-1:0];
        coef_wdata = coef_sat;
        tap_re     = issue || (r_state == naf_pkg::ST_RD);
        coef_re    = tap_re;
        if (r_state == naf_pkg::ST_CLEAR) begin
            tap_we     = 1'b1;
            tap_waddr  = r_k[AW-1:0];
            tap_wdata  = '0;
            coef_we    = 1'b1;
            coef_wdata = '0;
        end else if (in_xfer) begin
            tap_we = 1'b1;
        end else if (r_state == naf_pkg::ST_WR) begin
            coef_we = 1'b1;
        end
    end

    naf_ram #(.W(SW), .DEPTH(TAPS)) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (tap_waddr),
        .i_wdata (tap_wdata),
        .i_re    (tap_re),
        .i_raddr (r_taddr),
        .o_rdata (tap_rdata)
    );

    naf_ram #(.W(naf_pkg::COEF_W), .DEPTH(TAPS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_re    (coef_re),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (coef_rdata)
    );

    naf_div #(.DEN_W(EN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= naf_pkg::ST_CLEAR;
            r_k         <= '0;
            r_head      <= '0;
            r_step      <= naf_pkg::STEP_W'(naf_pkg::STEP_RST);
            r_rd_v      <= 1'b0;
            r_p_v       <= 1'b0;
            r_out_v     <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_step <= i_cfg_wr_data;
            end
            r_rd_v      <= issue;
            r_p_v       <= r_rd_v;
            r_div_start <= 1'b0;
            if (r_out_v && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                naf_pkg::ST_CLEAR: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == CW'(TAPS - 1)) begin
                        r_k     <= '0;
                        r_state <= naf_pkg::ST_IDLE;
                    end
                end
                naf_pkg::ST_IDLE: begin
                    if (in_xfer) begin
                        r_head  <= head_inc;
                        r_k     <= '0;
                        r_state <= naf_pkg::ST_ACC;
                    end
                end
                naf_pkg::ST_ACC: begin
                    if (issue) begin
                        r_k <= r_k + 1'b1;
                    end else if (!r_rd_v && !r_p_v) begin
                        r_state <= naf_pkg::ST_EST;
                    end
                end
                naf_pkg::ST_EST: begin
                    r_state <= naf_pkg::ST_ERR;
                end
                naf_pkg::ST_ERR: begin
                    if (out_free) begin
                        r_out_v <= 1'b1;
                        r_state <= naf_pkg::ST_SE;
                    end
                end
                naf_pkg::ST_SE: begin
                    r_k     <= '0;
                    r_state <= naf_pkg::ST_RD;
                end
                naf_pkg::ST_RD: begin
                    r_state <= naf_pkg::ST_MUL;
                end
                naf_pkg::ST_MUL: begin
                    r_div_start <= 1'b1;
                    r_state     <= naf_pkg::ST_DIV;
                end
                naf_pkg::ST_DIV: begin
                    if (div_done) begin
                        r_state <= naf_pkg::ST_WR;
                    end
                end
                naf_pkg::ST_WR: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == CW'(TAPS - 1)) begin
                        r_state <= naf_pkg::ST_IDLE;
                    end else begin
                        r_state <= naf_pkg::ST_RD;
                    end
                end
                default: r_state <= naf_pkg::ST_CLEAR;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_desired <= $signed(s_axis_tdata[31:16]);
            r_taddr   <= head_inc;
            r_acc     <= '0;
            r_energy  <= '0;
        end else if (issue || (r_state == naf_pkg::ST_WR)) begin
            r_taddr <= taddr_dec;
        end else if (r_state == naf_pkg::ST_SE) begin
            r_taddr <= r_head;
        end
        if (r_rd_v) begin
            r_p_cx <= $signed(coef_rdata) * $signed(tap_rdata);
            r_p_tt <= 31'($signed(tap_rdata) * $signed(tap_rdata));
        end
        if (r_p_v) begin
            r_acc    <= r_acc + ACC_W'(r_p_cx);
            r_energy <= r_energy + EN_W'(r_p_tt);
        end
        if (r_state == naf_pkg::ST_EST) begin
            r_est_full <= (r_acc + (ACC_W'(1) <<< (naf_pkg::FRAC_W - 1)))
                          >>> naf_pkg::FRAC_W;
        end
        if ((r_state == naf_pkg::ST_ERR) && out_free) begin
            r_err     <= err_sat;
            r_out_err <= err_sat;
            r_out_est <= est_sat;
        end
        if (r_state == naf_pkg::ST_SE) begin
            r_se  <= naf_pkg::SE_W'($signed({1'b0, r_step}) * r_err);
            r_den <= (r_energy == '0) ? EN_W'(1) : r_energy;
        end
        if (r_state == naf_pkg::ST_MUL) begin
            r_coef <= $signed(coef_rdata);
            r_num  <= naf_pkg::PROD_W'(r_se * $signed(tap_rdata));
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_out_est, r_out_err};

    // checks
    `NAF_ASSERT_NEXT(a_accept_starts, in_xfer, r_state == naf_pkg::ST_ACC, "accept did not start estimate pass")
    `NAF_ASSERT_NOW(a_div_done_state, div_done, r_state == naf_pkg::ST_DIV, "divider finished outside divide state")
    `NAF_ASSERT_NEXT(a_result_hold, (r_state == naf_pkg::ST_ERR) && r_out_v && !m_axis_tready, r_state == naf_pkg::ST_ERR, "result overwrote a pending transfer")
    `NAF_ASSERT_NOW(a_coef_index, coef_we, r_k < CW'(TAPS), "coefficient write beyond taps")
endmodule
